>>> src/hex_record_halfword_parser_top_defines.svh
`ifndef HEX_RECORD_HALFWORD_PARSER_TOP_DEFINES_SVH
`define HEX_RECORD_HALFWORD_PARSER_TOP_DEFINES_SVH

// checked on every clock edge outside of reset
`define HRHP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define HRHP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> src/hrhp_pkg.sv
package hrhp_pkg;

    localparam logic [31:0] FlashBaseReset = 32'h0800_0000;
    localparam logic [9:0]  PosMax         = 10'd1023;
    localparam logic [9:0]  FirstDataPos   = 10'd9;
    localparam logic [9:0]  LastCountPos   = 10'd2;
    localparam logic [9:0]  LastOffsetPos  = 10'd6;
    localparam logic [7:0]  UpperHexBias   = 8'd55;

    // non-hex characters, lowercase included, decode as zero
    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        case (c) inside
            ["0":"9"]: t = c - 8'h30;
            ["A":"F"]: t = c - UpperHexBias;
            default:   t = 8'd0;
        endcase
        return t[3:0];
    endfunction

endpackage

>>> src/hex_record_halfword_parser_top.sv
// Hex record parser: takes one ASCII character of a hex record per request
// (i_record_start on the colon) and emits one flash write per four data digits,
// at address (flash base OR record offset) + 2 * group index, with the last
// group of the record flagged. A character is accepted every cycle while the
// input register can move on; it is decoded into the input register and then
// processed into the output register, so throughput is one character per cycle,
// limited only by the output being taken. The flash base is written through
// i_cfg_wr_en / i_cfg_wr_data; the user must do so only while no request is in
// flight, and the block itself has no check for this.
`include "hex_record_halfword_parser_top_defines.svh"

module hex_record_halfword_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_ascii_char,
    input  logic        i_record_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_write_address,
    output logic [15:0] o_write_halfword,
    output logic        o_last_in_record
);

    logic [31:0] r_flash_base;

    logic        r_s1_valid;
    logic [3:0]  r_s1_digit;
    logic        r_s1_start;

    logic [9:0]  r_pos,        n_pos;
    logic [7:0]  r_byte_count, n_byte_count;
    logic [15:0] r_offset,     n_offset;
    logic [11:0] r_acc,        n_acc;

    logic        r_out_valid,  n_out_valid;
    logic [31:0] r_out_addr,   n_out_addr;
    logic [15:0] r_out_hw,     n_out_hw;
    logic        r_out_last,   n_out_last;

    logic        can_move;
    logic        s1_fire;
    logic        in_fire;
    logic [9:0]  p;
    logic [9:0]  q;
    logic [7:0]  group;
    logic [1:0]  digit_sel;
    logic [7:0]  groups;

    assign can_move   = !r_out_valid || i_out_ready;
    assign s1_fire    = r_s1_valid && can_move;
    assign o_in_ready = !r_s1_valid || can_move;
    assign in_fire    = i_in_valid && o_in_ready;

    assign p         = r_s1_start ? 10'd0 : r_pos;
    assign q         = p - hrhp_pkg::FirstDataPos;
    assign group     = q[9:2];
    assign digit_sel = q[1:0];
    assign groups    = {1'b0, r_byte_count[7:1]};

    always_comb begin
        n_pos        = r_pos;
        n_byte_count = r_byte_count;
        n_offset     = r_offset;
        n_acc        = r_acc;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_addr   = r_out_addr;
        n_out_hw     = r_out_hw;
        n_out_last   = r_out_last;
        if (s1_fire) begin
            n_pos = (p < hrhp_pkg::PosMax) ? p + 10'd1 : hrhp_pkg::PosMax;
            if (p == 10'd0) begin
                n_byte_count = 8'd0;
                n_offset     = 16'd0;
                n_acc        = 12'd0;
            end else if (p <= hrhp_pkg::LastCountPos) begin
                n_byte_count = {r_byte_count[3:0], r_s1_digit};
            end else if (p <= hrhp_pkg::LastOffsetPos) begin
                n_offset = {r_offset[11:0], r_s1_digit};
            end else if (p >= hrhp_pkg::FirstDataPos && group < groups) begin
                if (digit_sel != 2'd3) begin
                    n_acc = {r_acc[7:0], r_s1_digit};
                end else begin
                    n_acc       = 12'd0;
                    n_out_valid = 1'b1;
                    n_out_hw    = {r_acc, r_s1_digit};
                    n_out_addr  = (r_flash_base | {16'd0, r_offset})
                                + {23'd0, group, 1'b0};
                    n_out_last  = ({1'b0, group} + 9'd1) == {1'b0, groups};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flash_base <= hrhp_pkg::FlashBaseReset;
            r_s1_valid   <= 1'b0;
            r_pos        <= 10'd0;
            r_byte_count <= 8'd0;
            r_offset     <= 16'd0;
            r_acc        <= 12'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_flash_base <= i_cfg_wr_data;
            end
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            r_pos        <= n_pos;
            r_byte_count <= n_byte_count;
            r_offset     <= n_offset;
            r_acc        <= n_acc;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_digit <= hrhp_pkg::hex_digit(i_ascii_char);
            r_s1_start <= i_record_start;
        end
        r_out_addr <= n_out_addr;
        r_out_hw   <= n_out_hw;
        r_out_last <= n_out_last;
    end

    assign o_out_valid      = r_out_valid;
    assign o_write_address  = r_out_addr;
    assign o_write_halfword = r_out_hw;
    assign o_last_in_record = r_out_last;

    `HRHP_ASSERT(a_s1_holds, r_s1_valid && !can_move |=> r_s1_valid && $stable(r_s1_digit) && $stable(r_s1_start), "stalled input stage lost its request")
    `HRHP_ASSERT(a_pos_step, s1_fire && !r_s1_start && r_pos != hrhp_pkg::PosMax |=> r_pos == $past(r_pos) + 10'd1, "position counter did not advance")
    `HRHP_ASSERT(a_start_clears, s1_fire && r_s1_start |=> r_byte_count == 8'd0 && r_offset == 16'd0 && r_acc == 12'd0, "record start did not clear header state")
    `HRHP_ASSERT(a_out_source, $rose(o_out_valid) |-> $past(s1_fire), "result appeared without a processed character")
    `HRHP_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_out_valid && !r_s1_valid, "reset left a request in flight")

endmodule

>>> bench/tb_hex_record_halfword_parser_top.sv
`timescale 1ns / 1ps

typedef struct {
    logic [31:0] addr;
    logic [15:0] halfword;
    logic        last_flag;
} flash_write_t;

// tracks the record parser state and the flash writes still owed by the block
class flash_write_tracker;
    logic [31:0] flash_base;
    logic [9:0]  char_pos;
    logic [7:0]  byte_count;
    logic [15:0] rec_offset;
    logic [11:0] digit_acc;
    logic [6:0]  hw_index;
    flash_write_t pending_writes[$];
    int unsigned errors;

    function new();
        flash_base = hrhp_pkg::FlashBaseReset;
        char_pos   = '0;
        byte_count = '0;
        rec_offset = '0;
        digit_acc  = '0;
        hw_index   = '0;
        errors     = 0;
    endfunction

    static function logic [3:0] nibble_of(logic [7:0] c);
        if (c >= "0" && c <= "9") return 4'(c - "0");
        if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
        return 4'd0;
    endfunction

    function int unsigned pending();
        return pending_writes.size();
    endfunction

    function void take_char(logic [7:0] c, logic st);
        logic [9:0]   p;
        logic [9:0]   q;
        logic [3:0]   d;
        logic [7:0]   grp;
        logic [6:0]   groups;
        flash_write_t w;
        p = st ? 10'd0 : char_pos;
        d = nibble_of(c);
        if (p == 10'd0) begin
            byte_count = '0;
            rec_offset = '0;
            digit_acc  = '0;
            hw_index   = '0;
        end else if (p <= hrhp_pkg::LastCountPos) begin
            byte_count = {byte_count[3:0], d};
        end else if (p <= hrhp_pkg::LastOffsetPos) begin
            rec_offset = {rec_offset[11:0], d};
        end else if (p >= hrhp_pkg::FirstDataPos) begin
            q      = p - hrhp_pkg::FirstDataPos;
            grp    = q[9:2];
            groups = byte_count[7:1];
            if (grp < {1'b0, groups}) begin
                if (q[1:0] != 2'd3) begin
                    digit_acc = {digit_acc[7:0], d};
                end else begin
                    w.addr      = (flash_base | {16'h0, rec_offset}) + {23'h0, grp, 1'b0};
                    w.halfword  = {digit_acc, d};
                    w.last_flag = (int'(grp) + 1 == int'(groups));
                    pending_writes.push_back(w);
                    digit_acc = '0;
                    hw_index  = 7'(grp + 8'd1);
                end
            end
        end
        char_pos = (p < hrhp_pkg::PosMax) ? p + 10'd1 : hrhp_pkg::PosMax;
    endfunction

    function void check_write(logic [31:0] addr, logic [15:0] hw, logic last_flag);
        flash_write_t w;
        if (pending_writes.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected write: addr %h data %h last %b", addr, hw, last_flag);
            return;
        end
        w = pending_writes.pop_front();
        if (addr !== w.addr || hw !== w.halfword || last_flag !== w.last_flag) begin
            errors++;
            if (errors <= 10)
                $display("write mismatch: expected addr %h data %h last %b, got %h %h %b",
                         w.addr, w.halfword, w.last_flag, addr, hw, last_flag);
        end
    endfunction
endclass

module tb_hex_record_halfword_parser_top;
    localparam int unsigned CycleLimit = 200000;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_wr_en    = 1'b0;
    logic [31:0] i_cfg_wr_data  = '0;
    logic        i_in_valid     = 1'b0;
    logic [7:0]  i_ascii_char   = '0;
    logic        i_record_start = 1'b0;
    logic        i_out_ready    = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [31:0] o_write_address;
    logic [15:0] o_write_halfword;
    logic        o_last_in_record;

    flash_write_tracker sb;
    bit          steady      = 1'b0;
    int unsigned chars_sent  = 0;
    int unsigned cycle_count = 0;

    hex_record_halfword_parser_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_ascii_char     (i_ascii_char),
        .i_record_start   (i_record_start),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_write_address  (o_write_address),
        .o_write_halfword (o_write_halfword),
        .o_last_in_record (o_last_in_record)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(0, 99) >= 20);
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_write(o_write_address, o_write_halfword, o_last_in_record);
    end

    task automatic send_char(input logic [7:0] c, input logic st);
        if (!steady && $urandom_range(0, 99) < 10) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_ascii_char   <= c;
        i_record_start <= st;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.take_char(c, st);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], 1'b0);
    endtask

    // mostly proper uppercase digits, now and then lowercase or junk
    task automatic send_digit(input logic [3:0] v);
        logic [7:0] c;
        if ($urandom_range(0, 99) < 92)
            c = (v < 4'd10) ? 8'("0" + v) : 8'("A" + v - 4'd10);
        else if (v >= 4'd10)
            c = 8'("a" + v - 4'd10);
        else
            c = 8'($urandom_range(8'h47, 8'h7E));
        send_char(c, 1'b0);
    endtask

    task automatic wait_for_writes();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic set_base(input logic [31:0] v);
        wait_for_writes();
        // a character with no write may still be in the pipe
        repeat (8) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.flash_base = v;
    endtask

    function automatic logic [7:0] pick_count();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)  return 8'd0;
        if (r < 20) return 8'({$urandom_range(0, 7), 1'b1});
        if (r < 90) return 8'(2 * $urandom_range(1, 8));
        return 8'($urandom_range(17, 64));
    endfunction

    task automatic send_record(input logic [7:0] n_bytes, input bit pause_mid);
        logic [15:0] offs;
        int unsigned n_digits;
        int unsigned cut;
        offs     = 16'($urandom);
        n_digits = 2 * n_bytes;
        cut      = (!pause_mid && $urandom_range(0, 99) < 10) ?
                   $urandom_range(0, n_digits) : n_digits;
        // some records miss the start flag or carry it on another character
        case ($urandom_range(0, 19))
            0:       send_char(":", 1'b0);
            1:       send_char(8'($urandom), 1'b1);
            default: send_char(":", 1'b1);
        endcase
        send_digit(n_bytes[7:4]);
        send_digit(n_bytes[3:0]);
        for (int i = 3; i >= 0; i--)
            send_digit(offs[4*i +: 4]);
        send_digit(4'd0);
        send_digit(4'($urandom_range(0, 5)));
        for (int i = 0; i < cut; i++) begin
            send_digit(4'($urandom));
            if (pause_mid && i == 5)
                wait_for_writes();
        end
        if (cut == n_digits) begin
            send_digit(4'($urandom));
            send_digit(4'($urandom));
            if ($urandom_range(0, 1)) begin
                send_char(8'h0D, 1'b0);
                send_char(8'h0A, 1'b0);
            end
        end
    endtask

    task automatic run_records(input int unsigned n_chars);
        int unsigned stop_at;
        stop_at = chars_sent + n_chars;
        while (chars_sent < stop_at)
            send_record(pick_count(), 1'b0);
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // first record after reset has no start flag, type field at the char extremes
        send_char(":", 1'b0);
        send_text("02FFFF");
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_text("FFFF");
        // start flag on a non-colon, odd count, lowercase and junk digits
        send_char("a", 1'b1);
        send_text("a3Gz9F00fF0A");
        run_records(100);

        set_base(32'h0000_0000);
        send_record(8'd12, 1'b1);
        run_records(100);

        // address wraps past the top
        set_base(32'hFFFF_FFFF);
        run_records(100);

        set_base($urandom);
        steady = 1'b1;
        run_records(100);
        steady = 1'b0;

        wait_for_writes();
        repeat (20) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0d expected writes never arrived", sb.pending());
            sb.errors += sb.pending();
        end
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
